// ===== sv/mcodp_pkg.sv =====
// Shared constants for the matrix chain order block.
package mcodp_pkg;

    // Result field widths.
    localparam int COST_W = 40;
    localparam int IDX_W  = 4;
    localparam int ERR_W  = 2;

    // Largest cost a result can carry; larger values saturate to it.
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FEW  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_MANY = 2'd2;

endpackage

// ===== sv/mcodp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mcodp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/matrix_chain_order_dp.sv =====
// Matrix chain multiplication order solver: dimension loader, DP sequencer, result emitter.
//
// Usage:
//   Input channel (i_valid / o_stall): one dimension word per transfer, in chain
//   order d0..dn; i_is_last marks dn and starts the solve. o_stall is high from
//   the last word until the run's final result has been moved into the output
//   register.
//   Output channel (o_valid / i_stall): one word per subchain i..j of the upper
//   triangle (diagonal included), row-major, o_last_result on the final word.
//   A chain of fewer than two or more than MAX_MATRICES+1 dimensions yields a
//   single word with o_error and o_last_result set and all other fields zero.
//   Solve: one shared multiply/add/compare datapath visits each split k in the
//   states S_K_RD, S_MUL1, S_MUL2 and S_CMP; each subchain adds a dimension fetch
//   (S_RD_I, S_RD_J) and a table write (S_WR). Emission passes each word through
//   S_E_RD and S_E_LD, reading the cost/split table read port, and waits while
//   the receiver stalls.
//   Receiver stall holds the output word and pauses the emitter; nothing is lost.
//   Reset: synchronous, active low; clears the sequencer, the dimension count and
//   the output valid. Table contents are not cleared; only written entries are used.
module matrix_chain_order_dp #(
    parameter int MAX_MATRICES = 8,
    parameter int DIM_BITS     = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // dimension input
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [DIM_BITS-1:0]         i_dim,
    input  logic                        i_is_last,
    // result output
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mcodp_pkg::IDX_W-1:0]  o_row,
    output logic [mcodp_pkg::IDX_W-1:0]  o_col,
    output logic [mcodp_pkg::COST_W-1:0] o_cost,
    output logic [mcodp_pkg::IDX_W-1:0]  o_split,
    output logic [mcodp_pkg::ERR_W-1:0]  o_error,
    output logic                        o_last_result
);

    // index widths: IW holds 0..MAX_MATRICES, CIW a 0-based table row/col
    localparam int IW        = $clog2(MAX_MATRICES + 1);
    localparam int CIW       = $clog2(MAX_MATRICES);
    localparam int NW        = $clog2(MAX_MATRICES + 3);
    localparam int DIM_CAP   = MAX_MATRICES + 1;
    localparam int COUNT_SAT = MAX_MATRICES + 2;
    localparam int TAW       = 2 * CIW;
    localparam int TDEPTH    = 2 ** TAW;
    // internal cost width: (m-1) products of three dims never overflow it
    localparam int CSW       = 3 * DIM_BITS + IW;
    localparam int OW        = (CSW > mcodp_pkg::COST_W) ? CSW : mcodp_pkg::COST_W;

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_RD_I = 4'd2;
    localparam logic [3:0] S_RD_J = 4'd3;
    localparam logic [3:0] S_K_RD = 4'd4;
    localparam logic [3:0] S_MUL1 = 4'd5;
    localparam logic [3:0] S_MUL2 = 4'd6;
    localparam logic [3:0] S_CMP  = 4'd7;
    localparam logic [3:0] S_WR   = 4'd8;
    localparam logic [3:0] S_E_RD = 4'd9;
    localparam logic [3:0] S_E_LD = 4'd10;

    logic [3:0]                    r_state;
    logic [NW-1:0]                 r_cnt;
    logic [IW-1:0]                 r_m, r_len, r_i, r_j, r_k;
    logic [mcodp_pkg::ERR_W-1:0]    r_err;
    logic [DIM_BITS-1:0]           r_di, r_dj;
    logic [2*DIM_BITS-1:0]         r_p1;
    logic [3*DIM_BITS-1:0]         r_p2;
    logic [CSW-1:0]                r_csum, r_best;
    logic [IW-1:0]                 r_bestk;

    // output register
    logic                          r_ovld;
    logic [mcodp_pkg::IDX_W-1:0]    r_row, r_col, r_split;
    logic [mcodp_pkg::COST_W-1:0]   r_cost;
    logic [mcodp_pkg::ERR_W-1:0]    r_oerr;
    logic                          r_olast;

    logic                          w_acc;
    logic                          w_out_free;
    logic                          w_oload;
    logic [NW-1:0]                 w_n;
    logic [IW-1:0]                 w_i0, w_j0, w_k0, w_k1, w_dim_raddr;
    logic [TAW-1:0]                w_a_raddr, w_b_raddr, w_waddr;
    logic                          w_emit;
    logic [DIM_BITS-1:0]           w_dim_q;
    logic [CSW-1:0]                w_ca_q, w_cb_q, w_ca, w_cb, w_q;
    logic [IW-1:0]                 w_split_q;
    logic [mcodp_pkg::COST_W-1:0]   w_cost_sat;
    logic                          w_diag;
    logic [2*DIM_BITS-1:0]         w_mul_a;
    logic [DIM_BITS-1:0]           w_mul_b;
    logic [3*DIM_BITS-1:0]         w_mul_p;

    assign w_acc      = i_valid && !o_stall;
    assign w_out_free = !r_ovld || !i_stall;
    assign w_oload    = ((r_state == S_ERR) || (r_state == S_E_LD)) && w_out_free;
    assign w_n        = (r_cnt < NW'(COUNT_SAT)) ? r_cnt + NW'(1) : r_cnt;

    // 0-based table coordinates
    assign w_i0 = r_i - IW'(1);
    assign w_j0 = r_j - IW'(1);
    assign w_k0 = r_k - IW'(1);
    assign w_k1 = r_k;
    assign w_emit = (r_state == S_E_RD) || (r_state == S_E_LD);

    // A port reads cost(i..k) or, while emitting, cost(i..j); B port reads cost(k+1..j)
    assign w_a_raddr = w_emit ? {w_i0[CIW-1:0], w_j0[CIW-1:0]}
                              : {w_i0[CIW-1:0], w_k0[CIW-1:0]};
    assign w_b_raddr = {w_k1[CIW-1:0], w_j0[CIW-1:0]};
    assign w_waddr   = {w_i0[CIW-1:0], w_j0[CIW-1:0]};

    always_comb begin
        unique case (r_state)
            S_RD_I:  w_dim_raddr = w_i0;
            S_RD_J:  w_dim_raddr = r_j;
            default: w_dim_raddr = r_k;
        endcase
    end

    mcodp_ram #(.WIDTH(DIM_BITS), .DEPTH(DIM_CAP)) u_dim_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc && (r_cnt < NW'(DIM_CAP))),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata (i_dim),
        .i_raddr (w_dim_raddr),
        .o_rdata (w_dim_q)
    );

    // two copies of the cost table so both operands arrive in the same cycle
    mcodp_ram #(.WIDTH(CSW), .DEPTH(TDEPTH)) u_cost_a_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR),
        .i_waddr (w_waddr),
        .i_wdata (r_best),
        .i_raddr (w_a_raddr),
        .o_rdata (w_ca_q)
    );

    mcodp_ram #(.WIDTH(CSW), .DEPTH(TDEPTH)) u_cost_b_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR),
        .i_waddr (w_waddr),
        .i_wdata (r_best),
        .i_raddr (w_b_raddr),
        .o_rdata (w_cb_q)
    );

    mcodp_ram #(.WIDTH(IW), .DEPTH(TDEPTH)) u_split_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR),
        .i_waddr (w_waddr),
        .i_wdata (r_bestk),
        .i_raddr (w_a_raddr),
        .o_rdata (w_split_q)
    );

    // one multiplier: d[i-1]*d[k] in MUL1, then that product times d[j] in MUL2
    assign w_mul_a = (r_state == S_MUL1) ? (2*DIM_BITS)'(r_di) : r_p1;
    assign w_mul_b = (r_state == S_MUL1) ? w_dim_q : r_dj;
    assign w_mul_p = (3*DIM_BITS)'(w_mul_a) * (3*DIM_BITS)'(w_mul_b);

    // diagonal entries are never written; they read as zero cost
    assign w_ca = (r_k == r_i) ? '0 : w_ca_q;
    assign w_cb = ((r_k + IW'(1)) == r_j) ? '0 : w_cb_q;
    assign w_q  = r_csum + CSW'(r_p2);

    assign w_diag     = (r_i == r_j);
    assign w_cost_sat = (OW'(w_ca_q) > OW'(mcodp_pkg::COST_MAX)) ? mcodp_pkg::COST_MAX
                                                               : mcodp_pkg::COST_W'(w_ca_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (w_oload) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        r_cnt <= i_is_last ? '0 : w_n;
                        if (i_is_last) begin
                            r_m   <= IW'(w_n - NW'(1));
                            r_i   <= IW'(1);
                            if (w_n < NW'(2)) begin
                                r_err   <= mcodp_pkg::ERR_FEW;
                                r_state <= S_ERR;
                            end else if (w_n > NW'(DIM_CAP)) begin
                                r_err   <= mcodp_pkg::ERR_MANY;
                                r_state <= S_ERR;
                            end else if (w_n == NW'(2)) begin
                                r_j     <= IW'(1);
                                r_state <= S_E_RD;
                            end else begin
                                r_len   <= IW'(2);
                                r_j     <= IW'(2);
                                r_state <= S_RD_I;
                            end
                        end
                    end
                end
                S_ERR: begin
                    if (w_out_free) begin
                        r_row   <= '0;
                        r_col   <= '0;
                        r_cost  <= '0;
                        r_split <= '0;
                        r_oerr  <= r_err;
                        r_olast <= 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_RD_I: begin
                    r_state <= S_RD_J;
                end
                S_RD_J: begin
                    r_di    <= w_dim_q;
                    r_k     <= r_i;
                    r_state <= S_K_RD;
                end
                S_K_RD: begin
                    // on the first split the read port still holds d[j]
                    if (r_k == r_i) begin
                        r_dj <= w_dim_q;
                    end
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p1    <= w_mul_p[2*DIM_BITS-1:0];
                    r_csum  <= w_ca + w_cb;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2    <= w_mul_p;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // strict less-than keeps the smaller split on ties
                    if ((r_k == r_i) || (w_q < r_best)) begin
                        r_best  <= w_q;
                        r_bestk <= r_k;
                    end
                    if ((r_k + IW'(1)) == r_j) begin
                        r_state <= S_WR;
                    end else begin
                        r_k     <= r_k + IW'(1);
                        r_state <= S_K_RD;
                    end
                end
                S_WR: begin
                    if (r_j == r_m) begin
                        if (r_len == r_m) begin
                            r_i     <= IW'(1);
                            r_j     <= IW'(1);
                            r_state <= S_E_RD;
                        end else begin
                            r_len   <= r_len + IW'(1);
                            r_i     <= IW'(1);
                            r_j     <= r_len + IW'(1);
                            r_state <= S_RD_I;
                        end
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_j     <= r_j + IW'(1);
                        r_state <= S_RD_I;
                    end
                end
                S_E_RD: begin
                    r_state <= S_E_LD;
                end
                S_E_LD: begin
                    if (w_out_free) begin
                        r_row   <= mcodp_pkg::IDX_W'(r_i);
                        r_col   <= mcodp_pkg::IDX_W'(r_j);
                        r_cost  <= w_diag ? '0 : w_cost_sat;
                        r_split <= w_diag ? '0 : mcodp_pkg::IDX_W'(w_split_q);
                        r_oerr  <= mcodp_pkg::ERR_NONE;
                        r_olast <= (r_i == r_m) && (r_j == r_m);
                        if (r_j == r_m) begin
                            if (r_i == r_m) begin
                                r_state <= S_LOAD;
                            end else begin
                                r_i     <= r_i + IW'(1);
                                r_j     <= r_i + IW'(1);
                                r_state <= S_E_RD;
                            end
                        end else begin
                            r_j     <= r_j + IW'(1);
                            r_state <= S_E_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_stall       = (r_state != S_LOAD);
    assign o_valid       = r_ovld;
    assign o_row         = r_row;
    assign o_col         = r_col;
    assign o_cost        = r_cost;
    assign o_split       = r_split;
    assign o_error       = r_oerr;
    assign o_last_result = r_olast;

endmodule
